/* rtl/core/voxel_histogram_range_engine_core_defines.svh */
// Assertion macros for the voxel histogram range engine checker.
// No dependencies; included by the checker file only.
`ifndef VOXEL_HISTOGRAM_RANGE_ENGINE_CORE_DEFINES_SVH
`define VOXEL_HISTOGRAM_RANGE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, ignored during reset
`define VHRE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored during reset
`define VHRE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define VHRE_ASSERT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/vhre_pkg.sv */
// Shared types and constants of the voxel histogram range engine.
// No dependencies.
package vhre_pkg;

  localparam int BIN_COUNT  = 65536;
  localparam int BIN_BITS   = $clog2(BIN_COUNT);
  localparam int COUNT_BITS = 32;
  localparam int Q_BITS     = 48;
  localparam int OUT_BITS   = 32;

  localparam logic [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
  localparam logic [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_REPORT = 2'd3
  } mode_t;

  localparam logic [2:0] VT_UINT8   = 3'd0;
  localparam logic [2:0] VT_INT8    = 3'd1;
  localparam logic [2:0] VT_UINT16  = 3'd2;
  localparam logic [2:0] VT_INT16   = 3'd3;
  localparam logic [2:0] VT_INT32   = 3'd4;
  localparam logic [2:0] VT_FLOAT32 = 3'd5;

  localparam logic [1:0] REG_VOXEL_TYPE    = 2'd0;
  localparam logic [1:0] REG_RANGE_ORIGIN  = 2'd1;
  localparam logic [1:0] REG_BINS_PER_UNIT = 2'd2;

  typedef struct packed {
    mode_t               mode;
    logic [Q_BITS-1:0]   v;
    logic [BIN_BITS-1:0] idx;
    logic                scaled;
    logic                addr_ok;
  } cls_item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

/* rtl/core/voxel_histogram_range_engine_core.sv */
// Top level of the voxel histogram range engine: configuration registers,
// front end and back end. Depends on vhre_pkg, vhre_front and vhre_back.
//
// Queue-like block: push/full in, empty/pop out, register writes on a valid/ready
// channel (always ready). After reset, and after every clear item, the bin
// memory is swept one bin a cycle over all BIN_COUNT (65536) bins, while full
// stays high. Items run one at a time in the back end: an add reads and writes
// back its bin for 8/16-bit types, and for int32/float32 first forms the
// difference, two partial products of the 48x32 scaling multiply, and the sum
// and clamp before that memory read-modify-write, skipping the multiply and
// sum (bin 0) when the scale is zero or the sample is at or below the origin;
// a bin read and a range report each wait for the previous result to be taken.
// A clear starts the sweep. A two-entry queue after classification lets input keep flowing meanwhile.
module voxel_histogram_range_engine_core
  import vhre_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode,
  input  logic [31:0]         sample,
  input  logic [15:0]         bin_address,
  output logic                empty,
  input  logic                pop,
  output logic [OUT_BITS-1:0] bin_count,
  output logic [Q_BITS-1:0]   range_low,
  output logic [Q_BITS-1:0]   range_high,
  output logic                is_empty,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [Q_BITS-1:0]   cfg_data
);

  logic [2:0]        voxel_type;
  logic [Q_BITS-1:0] range_origin;
  logic [31:0]       bins_per_unit;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  cls_item_t         q_item;
  back_status_t      status;

  assign cfg_ready = 1'b1;
  assign full      = q_full || status.clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      voxel_type    <= VT_UINT8;
      range_origin  <= '0;
      bins_per_unit <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VOXEL_TYPE:    voxel_type    <= cfg_data[2:0];
        REG_RANGE_ORIGIN:  range_origin  <= cfg_data;
        REG_BINS_PER_UNIT: bins_per_unit <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  vhre_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push_ok     (push && !full),
    .mode        (mode),
    .sample      (sample),
    .bin_address (bin_address),
    .voxel_type  (voxel_type),
    .q_full      (q_full),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  vhre_back u_back (
    .clk           (clk),
    .rst           (rst),
    .range_origin  (range_origin),
    .bins_per_unit (bins_per_unit),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .status        (status),
    .pop           (pop),
    .empty         (empty),
    .bin_count     (bin_count),
    .range_low     (range_low),
    .range_high    (range_high),
    .is_empty      (is_empty)
  );

endmodule

/* rtl/core/vhre_front.sv */
// Front end: classifies each item (Q32.16 conversion, direct bin index)
// and holds it in a two-entry queue for the back end. Uses vhre_pkg.
module vhre_front
  import vhre_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push_ok,
  input  logic [1:0]          mode,
  input  logic [31:0]         sample,
  input  logic [15:0]         bin_address,
  input  logic [2:0]          voxel_type,
  output logic                q_full,
  output logic                q_valid,
  output cls_item_t           q_item,
  input  logic                q_pop
);

  cls_item_t   slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  cls_item_t   cls;

  logic [7:0]        fe;
  logic [23:0]       fm;
  logic signed [9:0] sh;
  logic [Q_BITS-1:0] fmag;
  logic [Q_BITS-1:0] fq;
  logic [16:0]       nidx;
  logic [Q_BITS-1:0] nv;

  always_comb begin
    fe   = sample[30:23];
    fm   = {1'b1, sample[22:0]};
    sh   = $signed({2'b00, fe}) - 10'sd134;
    fmag = '0;
    if (sh >= 10'sd0) begin
      fmag = Q_BITS'(fm) << sh[4:0];
    end else if (sh > -10'sd32) begin
      fmag = Q_BITS'(fm >> (-sh));
    end
    if (fe == 8'hFF) begin
      fq = (sample[22:0] != '0) ? '0 : (sample[31] ? Q_MIN : Q_MAX);
    end else if (fe == 8'h00) begin
      fq = '0;
    end else if (sh >= 10'sd24) begin
      fq = sample[31] ? Q_MIN : Q_MAX;
    end else begin
      fq = sample[31] ? (~fmag + 1'b1) : fmag;
    end
  end

  always_comb begin
    cls.mode    = mode_t'(mode);
    cls.scaled  = 1'b0;
    cls.addr_ok = 17'(bin_address) < 17'(BIN_COUNT);
    nidx        = 17'(sample[7:0]);
    nv          = {{(Q_BITS-24){1'b0}}, sample[7:0], 16'h0000};
    case (voxel_type)
      VT_INT8: begin
        nidx = 17'({~sample[7], sample[6:0]});
        nv   = {{(Q_BITS-24){sample[7]}}, sample[7:0], 16'h0000};
      end
      VT_UINT16: begin
        nidx = 17'(sample[15:0]);
        nv   = {{(Q_BITS-32){1'b0}}, sample[15:0], 16'h0000};
      end
      VT_INT16: begin
        nidx = 17'({~sample[15], sample[14:0]});
        nv   = {{(Q_BITS-32){sample[15]}}, sample[15:0], 16'h0000};
      end
      VT_INT32: begin
        cls.scaled = 1'b1;
        nv         = {sample, 16'h0000};
      end
      VT_FLOAT32: begin
        cls.scaled = 1'b1;
        nv         = fq;
      end
      default: begin
      end
    endcase
    cls.v = nv;
    if (nidx > 17'(BIN_COUNT - 1)) begin
      nidx = 17'(BIN_COUNT - 1);
    end
    if (cls.mode == MODE_ADD) begin
      cls.idx = nidx[BIN_BITS-1:0];
    end else begin
      cls.idx = bin_address[BIN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push_ok) begin
        slots[wr_ptr] <= cls;
        wr_ptr        <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push_ok) - 2'(q_pop && q_valid);
    end
  end

  assign q_full  = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign q_item  = slots[rd_ptr];

endmodule

/* rtl/core/vhre_back.sv */
// Back end: bin memory with clearing pass, scaled bin arithmetic,
// range tracking and the result register. Uses vhre_pkg.
module vhre_back
  import vhre_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [Q_BITS-1:0]   range_origin,
  input  logic [31:0]         bins_per_unit,
  input  logic                q_valid,
  input  cls_item_t           q_item,
  output logic                q_pop,
  output back_status_t        status,
  input  logic                pop,
  output logic                empty,
  output logic [OUT_BITS-1:0] bin_count,
  output logic [Q_BITS-1:0]   range_low,
  output logic [Q_BITS-1:0]   range_high,
  output logic                is_empty
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIFF, S_MUL_LO, S_MUL_HI, S_SUM, S_READ, S_WRITE, S_EMIT
  } state_t;

  state_t              state;
  cls_item_t           item;
  logic [BIN_BITS-1:0] idx;
  logic [BIN_BITS-1:0] clr_cnt;
  logic [Q_BITS:0]     diff;
  logic [63:0]         prod_lo;
  logic [Q_BITS-1:0]   prod_hi;
  logic [Q_BITS:0]     sum;
  logic [COUNT_BITS-1:0] mem [BIN_COUNT];
  logic [COUNT_BITS-1:0] rd_data;
  logic                  mem_we;
  logic [BIN_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [63:0]           cnt_wide;
  logic                  seen_any;
  logic [Q_BITS-1:0]     least;
  logic [Q_BITS-1:0]     greatest;
  logic                  out_valid;
  logic                  emit_go;

  always_comb begin
    mem_we    = (state == S_CLEAR) || (state == S_WRITE);
    mem_waddr = (state == S_CLEAR) ? clr_cnt : idx;
    mem_wdata = '0;
    if (state == S_WRITE) begin
      mem_wdata = (&rd_data) ? rd_data : rd_data + 1'b1;
    end
    sum      = (Q_BITS+1)'(prod_hi) + (Q_BITS+1)'(prod_lo[63:32]);
    cnt_wide = 64'(rd_data);
    emit_go  = (state == S_EMIT) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      seen_any   <= 1'b0;
      least      <= '0;
      greatest   <= '0;
      range_low  <= '0;
      range_high <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == BIN_BITS'(BIN_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            idx  <= q_item.idx;
            unique case (q_item.mode)
              MODE_ADD: begin
                seen_any <= 1'b1;
                if (!seen_any || $signed(q_item.v) < $signed(least)) begin
                  least <= q_item.v;
                end
                if (!seen_any || $signed(q_item.v) > $signed(greatest)) begin
                  greatest <= q_item.v;
                end
                state <= q_item.scaled ? S_DIFF : S_READ;
              end
              MODE_READ: state <= S_READ;
              MODE_CLEAR: begin
                seen_any <= 1'b0;
                least    <= '0;
                greatest <= '0;
                clr_cnt  <= '0;
                state    <= S_CLEAR;
              end
              MODE_REPORT: state <= S_EMIT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DIFF: begin
          diff  <= {item.v[Q_BITS-1], item.v} - {range_origin[Q_BITS-1], range_origin};
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          if (bins_per_unit == '0 || diff[Q_BITS] || diff == '0) begin
            idx   <= '0;
            state <= S_READ;
          end else begin
            prod_lo <= 64'(diff[31:0]) * 64'(bins_per_unit);
            state   <= S_MUL_HI;
          end
        end
        S_MUL_HI: begin
          prod_hi <= Q_BITS'(diff[Q_BITS-1:32]) * Q_BITS'(bins_per_unit);
          state   <= S_SUM;
        end
        S_SUM: begin
          if (sum > (Q_BITS+1)'(BIN_COUNT - 1)) begin
            idx <= BIN_BITS'(BIN_COUNT - 1);
          end else begin
            idx <= sum[BIN_BITS-1:0];
          end
          state <= S_READ;
        end
        S_READ: begin
          state <= (item.mode == MODE_ADD) ? S_WRITE : S_EMIT;
        end
        S_WRITE: begin
          state <= S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            is_empty   <= !seen_any;
            range_low  <= least;
            range_high <= greatest;
            bin_count  <= '0;
            if (item.mode == MODE_READ && item.addr_ok) begin
              bin_count <= (cnt_wide > 64'hFFFF_FFFF) ? '1 : cnt_wide[OUT_BITS-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign q_pop           = (state == S_IDLE) && q_valid;
  assign status.clearing = (state == S_CLEAR);
  assign empty           = !out_valid;

endmodule

/* rtl/core/vhre_checker.sv */
// Port-level checks of the voxel histogram range engine, bound to the top level.
// Depends on vhre_pkg and voxel_histogram_range_engine_core_defines.svh.
`include "voxel_histogram_range_engine_core_defines.svh"

module vhre_checker
  import vhre_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic [OUT_BITS-1:0] bin_count,
  input logic [Q_BITS-1:0]   range_low,
  input logic [Q_BITS-1:0]   range_high,
  input logic                is_empty
);

  `VHRE_ASSERT_ALWAYS(a_reset_sweep, rst, full && empty, "no transfer while bins clear")
  `VHRE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(bin_count) && $stable(range_low), "result changed before transfer")
  `VHRE_ASSERT_NOW(a_empty_range, !empty && is_empty, range_low == '0 && range_high == '0, "range not zero when empty")
  `VHRE_ASSERT_NOW(a_range_order, !empty, $signed(range_low) <= $signed(range_high), "range low above high")

endmodule

bind voxel_histogram_range_engine_core vhre_checker u_vhre_checker (.*);

/* tb/tb_voxel_histogram_range_engine_core.sv */
// Testbench for voxel_histogram_range_engine_core: a directed table, then random phases with
// varying idling, checked against a behavioural histogram/range predictor or fixed table values.
// Depends on vhre_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_voxel_histogram_range_engine_core;
  import vhre_pkg::*;

  localparam int     WATCHDOG_LIMIT = 300000;
  localparam int     SETTLE_CYCLES  = 40;
  localparam longint Q_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint Q_LO = -64'sh8000_0000_0000;

  typedef struct {
    logic [31:0] count;
    logic [47:0] low;
    logic [47:0] high;
    logic        none;
  } hist_res_t;

  typedef struct {
    bit          is_cfg;
    mode_t       md;
    logic [31:0] smp;
    logic [15:0] addr;
    logic [1:0]  reg_idx;
    logic [47:0] reg_val;
    bit          typed;
    hist_res_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = MODE_ADD;
  logic [31:0] sample = '0;
  logic [15:0] bin_address = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] bin_count;
  logic [47:0] range_low;
  logic [47:0] range_high;
  logic        is_empty;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  voxel_histogram_range_engine_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .sample(sample),
    .bin_address(bin_address), .empty(empty), .pop(pop), .bin_count(bin_count),
    .range_low(range_low), .range_high(range_high), .is_empty(is_empty),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  int unsigned     hist_bins[int];
  longint          low_q, high_q;
  bit              any_seen;
  logic [2:0]      vt_reg;
  longint          origin_reg;
  longint unsigned bpu_reg;
  int              last_bin;

  hist_res_t       pending_q[$];
  int              recent_bins[$];
  int              errors = 0;
  int              items_sent = 0;
  int              results_seen = 0;
  int              cfg_writes = 0;
  int              idle_cycles = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  function automatic longint float_to_fixed(logic [31:0] b);
    int              e;
    int              sh;
    longint unsigned m;
    longint unsigned mag;
    e = int'(b[30:23]);
    m = 64'(b[22:0]);
    if (e == 255) return (m != 0) ? 0 : (b[31] ? Q_LO : Q_HI);
    if (e == 0) return 0;
    m = m | 64'h80_0000;
    sh = e - 134;
    if (sh >= 24) return b[31] ? Q_LO : Q_HI;
    if (sh >= 0) mag = m << sh;
    else if (-sh < 32) mag = m >> (-sh);
    else mag = 0;
    return b[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic int scale_to_bin(longint v);
    longint          d;
    longint unsigned ud;
    longint unsigned idx;
    d = v - origin_reg;
    if (bpu_reg == 0 || d <= 0) return 0;
    ud = d;
    idx = (ud >> 32) * bpu_reg + (((ud & 64'hFFFF_FFFF) * bpu_reg) >> 32);
    if (idx > 65535) idx = 65535;
    return int'(idx);
  endfunction

  function automatic void wipe_histogram();
    hist_bins.delete();
    low_q = 0;
    high_q = 0;
    any_seen = 0;
  endfunction

  function automatic void set_register(logic [1:0] idx, logic [47:0] val);
    case (idx)
      REG_VOXEL_TYPE:    vt_reg = val[2:0];
      REG_RANGE_ORIGIN:  origin_reg = longint'($signed(val));
      REG_BINS_PER_UNIT: bpu_reg = 64'(val[31:0]);
      default: ;
    endcase
  endfunction

  function automatic bit histogram_step(mode_t md, logic [31:0] s, logic [15:0] a,
                                        output hist_res_t r);
    longint v;
    int     idx;
    r = '{default: '0};
    if (md == MODE_CLEAR) begin
      wipe_histogram();
      return 0;
    end
    if (md == MODE_ADD) begin
      case (vt_reg)
        VT_INT8: begin
          v = $signed(s[7:0]);
          idx = int'(v + 128);
        end
        VT_UINT16: begin
          v = 64'(s[15:0]);
          idx = int'(v);
        end
        VT_INT16: begin
          v = $signed(s[15:0]);
          idx = int'(v + 32768);
        end
        VT_INT32: begin
          v = longint'($signed(s)) * 65536;
          idx = scale_to_bin(v);
        end
        VT_FLOAT32: begin
          v = float_to_fixed(s);
          idx = scale_to_bin(v);
        end
        default: begin
          v = 64'(s[7:0]);
          idx = int'(v);
        end
      endcase
      if (vt_reg != VT_INT32 && vt_reg != VT_FLOAT32) v = v * 65536;
      if (idx > 65535) idx = 65535;
      if (!hist_bins.exists(idx)) hist_bins[idx] = 0;
      if (hist_bins[idx] != 32'hFFFF_FFFF) hist_bins[idx]++;
      last_bin = idx;
      if (!any_seen) begin
        low_q = v;
        high_q = v;
        any_seen = 1;
      end else begin
        if (v < low_q) low_q = v;
        if (v > high_q) high_q = v;
      end
      return 0;
    end
    if (md == MODE_READ && hist_bins.exists(int'(a))) r.count = hist_bins[int'(a)];
    r.low = low_q[47:0];
    r.high = high_q[47:0];
    r.none = !any_seen;
    return 1;
  endfunction

  task automatic send_item(mode_t md, logic [31:0] s, logic [15:0] a, output bit has,
                           output hist_res_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push <= 1'b1;
    mode <= md;
    sample <= s;
    bin_address <= a;
    do @(posedge clk); while (full);
    items_sent++;
    last_bin = -1;
    has = histogram_step(md, s, a, r);
    if (last_bin >= 0) begin
      recent_bins.push_back(last_bin);
      if (recent_bins.size() > 16) void'(recent_bins.pop_front());
    end
  endtask

  task automatic write_register(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    set_register(idx, val);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_sample();
    logic [31:0] s;
    s = $urandom;
    if (vt_reg == VT_INT32) begin
      case ($urandom_range(3))
        0: s = $urandom_range(2000) - 1000;
        1: s = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        default: ;
      endcase
    end else if (vt_reg == VT_FLOAT32) begin
      case ($urandom_range(5))
        0: s[30:23] = 8'd0;
        1: s[30:23] = 8'd255;
        default: s[30:23] = 8'($urandom_range(100, 165));
      endcase
      if ($urandom_range(7) == 0) s[22:0] = '0;
    end
    return s;
  endfunction

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
      if (pop && !empty) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          hist_res_t w;
          w = pending_q.pop_front();
          if (bin_count !== w.count) begin
            $error("bin_count: expected %0h, got %0h", w.count, bin_count);
            errors++;
          end
          if (range_low !== w.low) begin
            $error("range_low: expected %0h, got %0h", w.low, range_low);
            errors++;
          end
          if (range_high !== w.high) begin
            $error("range_high: expected %0h, got %0h", w.high, range_high);
            errors++;
          end
          if (is_empty !== w.none) begin
            $error("is_empty: expected %0b, got %0b", w.none, is_empty);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  stim_row_t rows[$];

  task automatic row_item(mode_t md, logic [31:0] s, logic [15:0] a);
    rows.push_back('{0, md, s, a, 2'd0, 48'd0, 0, '{default: '0}});
  endtask

  task automatic row_typed(mode_t md, logic [15:0] a, logic [31:0] c, logic [47:0] lo,
                           logic [47:0] hi, logic none);
    rows.push_back('{0, md, 32'd0, a, 2'd0, 48'd0, 1, '{c, lo, hi, none}});
  endtask

  task automatic row_cfg(logic [1:0] idx, logic [47:0] val);
    rows.push_back('{1, MODE_ADD, 32'd0, 16'd0, idx, val, 0, '{default: '0}});
  endtask

  initial begin
    bit          has;
    hist_res_t   r;
    logic [47:0] val;
    mode_t       md;
    int          pick;
    wipe_histogram();
    vt_reg = VT_UINT8;
    origin_reg = 0;
    bpu_reg = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    row_typed(MODE_REPORT, 16'd0, 32'd0, 48'd0, 48'd0, 1'b1);
    row_typed(MODE_READ, 16'hFFFF, 32'd0, 48'd0, 48'd0, 1'b1);
    row_item(MODE_ADD, 32'hFFFF_FFFF, 16'd0);
    row_item(MODE_ADD, 32'h0000_0100, 16'd0);
    row_typed(MODE_READ, 16'd255, 32'd1, 48'd0, 48'hFF_0000, 1'b0);
    row_typed(MODE_READ, 16'd0, 32'd1, 48'd0, 48'hFF_0000, 1'b0);
    row_cfg(REG_VOXEL_TYPE, 48'(VT_INT8));
    row_item(MODE_ADD, 32'h0000_0080, 16'd0);
    row_item(MODE_ADD, 32'h0000_007F, 16'd0);
    row_cfg(REG_VOXEL_TYPE, 48'(VT_INT16));
    row_item(MODE_ADD, 32'h0000_8000, 16'd0);
    row_item(MODE_ADD, 32'h0000_7FFF, 16'd0);
    row_item(MODE_READ, 32'd0, 16'd0);
    row_cfg(REG_VOXEL_TYPE, 48'(VT_UINT16));
    row_item(MODE_ADD, 32'h0000_FFFF, 16'd0);
    row_item(MODE_READ, 32'd0, 16'hFFFF);
    row_cfg(REG_VOXEL_TYPE, 48'(VT_INT32));
    row_cfg(REG_RANGE_ORIGIN, 48'h8000_0000_0000);
    row_cfg(REG_BINS_PER_UNIT, 48'hFFFF_FFFF);
    row_item(MODE_ADD, 32'h8000_0000, 16'd0);
    row_item(MODE_ADD, 32'h7FFF_FFFF, 16'd0);
    row_item(MODE_READ, 32'd0, 16'hFFFF);
    row_cfg(REG_VOXEL_TYPE, 48'(VT_FLOAT32));
    row_item(MODE_ADD, 32'h7FC0_0000, 16'd0);
    row_item(MODE_ADD, 32'h7F80_0000, 16'd0);
    row_item(MODE_ADD, 32'hFF80_0000, 16'd0);
    row_item(MODE_ADD, 32'h0000_0001, 16'd0);
    row_item(MODE_ADD, 32'h4F80_0000, 16'd0);
    row_typed(MODE_REPORT, 16'd0, 32'd0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b0);
    row_cfg(REG_RANGE_ORIGIN, 48'h7FFF_FFFF_FFFF);
    row_item(MODE_ADD, 32'h3F80_0000, 16'd0);
    row_item(MODE_READ, 32'd0, 16'd0);
    row_cfg(REG_VOXEL_TYPE, 48'd7);
    row_item(MODE_ADD, 32'h0000_0042, 16'd0);
    row_item(MODE_CLEAR, 32'd0, 16'd0);
    row_typed(MODE_REPORT, 16'd0, 32'd0, 48'd0, 48'd0, 1'b1);

    send_idle_pct = 18;
    recv_idle_pct = 62;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        write_register(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_item(rows[i].md, rows[i].smp, rows[i].addr, has, r);
        if (has) pending_q.push_back(rows[i].typed ? rows[i].want : r);
      end
    end

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 18 : (p == 1) ? 62 : 0;
      recv_idle_pct = (p == 0) ? 62 : (p == 1) ? 18 : 0;
      for (int c = 0; c < 6; c++) begin
        drain();
        write_register(REG_VOXEL_TYPE, 48'($urandom_range(7)));
        case ($urandom_range(3))
          0: val = 48'h8000_0000_0000;
          1: val = 48'h7FFF_FFFF_FFFF;
          2: val = 48'({$urandom, $urandom});
          default: val = 48'(longint'($urandom_range(2000)) * 65536 - 64'd1000 * 65536);
        endcase
        write_register(REG_RANGE_ORIGIN, val);
        case ($urandom_range(3))
          0: val = 48'd0;
          1: val = 48'hFFFF_FFFF;
          default: val = 48'($urandom >> $urandom_range(31));
        endcase
        write_register(REG_BINS_PER_UNIT, val);
        for (int k = 0; k < 61; k++) begin
          pick = $urandom_range(99);
          md = (c == 1 && k == 0) ? MODE_CLEAR :
               (pick < 70) ? MODE_ADD : (pick < 86) ? MODE_READ : MODE_REPORT;
          if (md == MODE_READ && recent_bins.size() != 0 && $urandom_range(1))
            send_item(md, $urandom, 16'(recent_bins[$urandom_range(recent_bins.size() - 1)]),
                      has, r);
          else
            send_item(md, random_sample(), 16'($urandom), has, r);
          if (has) pending_q.push_back(r);
        end
      end
    end

    drain();
    $display("%0d items, %0d results, %0d register writes over all voxel types",
             items_sent, results_seen, cfg_writes);
    $display("three idling phases, clears after reset and mid-run included");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
